/* design/hpp_pkg.sv */
// Package for the header parameter parser: phase codes, payload structs,
// result codes and byte-class functions. No dependencies.

package hpp_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_GAP0 = 3'd0,   // gap before optional semicolon
        PH_GAP1 = 3'd1,   // gap after semicolon
        PH_NAME = 3'd2,
        PH_VAL  = 3'd3,   // unquoted value
        PH_QVAL = 3'd4,   // quoted value
        PH_ERR  = 3'd5    // silent until the last byte
    } t_phase;

    // char_kind codes
    localparam logic [1:0] KIND_DROP  = 2'd0;
    localparam logic [1:0] KIND_NAME  = 2'd1;
    localparam logic [1:0] KIND_VALUE = 2'd2;

    // error_code codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NAME_CHAR = 3'd1;
    localparam logic [2:0] ERR_VAL_CHAR  = 3'd2;
    localparam logic [2:0] ERR_OPEN_QUOTE = 3'd3;
    localparam logic [2:0] ERR_EMPTY_NAME = 3'd4;

    // Delimiter bytes
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HTAB  = 8'h09;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [1:0] char_kind;
        logic [7:0] char_out;
        logic       param_done;
        logic [2:0] error_code;
        logic       last_out;
    } t_out_item;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_HTAB);
    endfunction

    // Token characters: letters, digits and the listed punctuation
    function automatic logic is_tok(input logic [7:0] b);
        logic r;
        case (b) inside
            [8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Bytes allowed inside quotes (no escapes)
    function automatic logic is_qd(input logic [7:0] b);
        logic r;
        case (b) inside
            8'h09, 8'h20, 8'h21, [8'h23:8'h5B], [8'h5D:8'h7E],
            [8'h80:8'hFF]: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

/* design/hpp_step.sv */
// Per-byte decision logic of the header parameter parser: classifies one byte
// against the current phase and gives the result and the next phase.
// Depends on hpp_pkg.

module hpp_step (
    input  hpp_pkg::t_in_item  i_item,
    input  hpp_pkg::t_phase    i_phase,
    input  logic               i_name_seen,
    output hpp_pkg::t_out_item o_result,
    output hpp_pkg::t_phase    o_phase,
    output logic               o_name_seen
);
    import hpp_pkg::*;

    logic [7:0] b;
    logic       lst;
    t_phase     ph;
    logic       ns;
    logic       handled;
    logic [1:0] kind;
    logic [7:0] ch;
    logic       done;
    logic [2:0] err;

    assign b   = i_item.byte_in;
    assign lst = i_item.last;

    always_comb begin
        kind    = KIND_DROP;
        ch      = 8'h00;
        done    = 1'b0;
        err     = ERR_NONE;
        handled = 1'b0;
        ns      = i_name_seen;

        // unused codes fall back to the leading gap
        unique case (i_phase)
            PH_GAP1, PH_NAME, PH_VAL, PH_QVAL, PH_ERR: ph = i_phase;
            default: ph = PH_GAP0;
        endcase

        if (ph == PH_ERR) begin
            handled = 1'b1;
        end else if (ph == PH_GAP0 || ph == PH_GAP1) begin
            if (is_ws(b)) begin
                handled = 1'b1;
            end else if (ph == PH_GAP0 && b == CH_SEMI) begin
                ph      = PH_GAP1;
                handled = 1'b1;
            end else begin
                ph = PH_NAME;
                ns = 1'b0;
            end
        end

        if (!handled) begin
            if (ph != PH_QVAL && (b == CH_SEMI || is_ws(b))) begin
                if (ns) begin
                    done = 1'b1;
                end else begin
                    err = ERR_EMPTY_NAME;
                end
                ph = (b == CH_SEMI) ? PH_GAP1 : PH_GAP0;
            end else if (b == CH_EQ && ph != PH_QVAL) begin
                ph = PH_VAL;
            end else if (b == CH_QUOTE && ph != PH_NAME) begin
                ph = (ph == PH_QVAL) ? PH_VAL : PH_QVAL;
            end else if (ph == PH_NAME) begin
                if (is_tok(b)) begin
                    kind = KIND_NAME;
                    ch   = (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
                    ns   = 1'b1;
                end else begin
                    err = ERR_NAME_CHAR;
                end
            end else begin
                if ((ph == PH_QVAL) ? is_qd(b) : is_tok(b)) begin
                    kind = KIND_VALUE;
                    ch   = b;
                end else begin
                    err = ERR_VAL_CHAR;
                end
            end
        end

        // end of string while a parameter is open
        if (err == ERR_NONE && lst &&
            (ph == PH_NAME || ph == PH_VAL || ph == PH_QVAL)) begin
            if (ph == PH_QVAL) begin
                err = ERR_OPEN_QUOTE;
            end else if (!ns) begin
                err = ERR_EMPTY_NAME;
            end else begin
                done = 1'b1;
            end
        end

        if (err != ERR_NONE) begin
            ph   = PH_ERR;
            kind = KIND_DROP;
            ch   = 8'h00;
            done = 1'b0;
        end

        // rearm after every final byte
        if (lst) begin
            ph = PH_GAP0;
            ns = 1'b0;
        end

        o_result.char_kind  = kind;
        o_result.char_out   = ch;
        o_result.param_done = done;
        o_result.error_code = err;
        o_result.last_out   = lst;
        o_phase             = ph;
        o_name_seen         = ns;
    end

endmodule

/* design/header_parameter_parser.sv */
// Top level of the header parameter parser: input register, per-byte
// decision logic (hpp_step) and result register. Depends on hpp_pkg.
//
// Usage:
//   Feed the text of one parameter list (for example ;a=b;c="x y") one byte
//   per transfer on the input channel, with last set on the final byte.
//   Every input byte yields exactly one result transfer: char_kind says
//   whether char_out is a name byte (lowercased), a value byte or dropped;
//   param_done marks the byte on which a complete parameter ends; error_code
//   reports a bad name byte, bad value byte, open quote or empty name.
//   After an error the results stay zero until the final byte, then the
//   parser rearms for the next string.
// Timing:
//   Each byte passes the input register and then the result register.
//   One byte per clock while i_out_ready is high: the phase register moves
//   with the result register, so the next byte sees the new phase at once.
// Reset:
//   Synchronous, active low. Clears both stage valids, the phase (leading
//   gap) and the name-seen flag.
// Stalls:
//   When the receiver holds i_out_ready low, the result register holds;
//   the input register still takes one more byte, then o_in_ready drops
//   until the result is taken.

module header_parameter_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hpp_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hpp_pkg::t_out_item  o_out_item
);
    import hpp_pkg::*;

    // input stage
    logic      r_in_valid;
    t_in_item  r_in;
    // result stage
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;
    // parser state
    t_phase    r_phase;
    logic      r_name_seen;

    t_out_item step_result;
    t_phase    step_phase;
    logic      step_name_seen;
    logic      out_free;
    logic      advance;

    // result slot empties when it is empty or being taken this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    hpp_step u_step (
        .i_item      (r_in),
        .i_phase     (r_phase),
        .i_name_seen (r_name_seen),
        .o_result    (step_result),
        .o_phase     (step_phase),
        .o_name_seen (step_name_seen)
    );

    always_comb begin
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_GAP0;
            r_name_seen <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_out_valid <= n_out_valid;
            // advance the parser only when the byte's result is registered
            if (advance) begin
                r_phase     <= step_phase;
                r_name_seen <= step_name_seen;
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
